// ----- hdl/rsv_pkg.sv -----
`default_nettype none
package rsv_pkg;

    localparam int CNT_W   = 24;
    localparam int SMP_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int SUM_W   = 40;
    localparam int SQ_W    = 55;
    localparam int MAG_W   = SMP_W;
    localparam int MPL_W   = 40;           // serial operand, one bit per cycle
    localparam int MCD_W   = 56;           // parallel operand
    localparam int PROD_W  = 96;
    localparam int QUO_W   = 48;           // quotient bits, variance with 2*FRAC_W fraction bits
    localparam int DVD_W   = 2 * QUO_W;
    localparam int VAR_W   = 39;
    localparam int DEV_W   = 24;
    localparam int STEP_W  = 6;
    localparam int MUL_STEPS  = MPL_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = QUO_W / 2;

    typedef struct packed {
        logic        [CNT_W-1:0] count;
        logic signed [SUM_W-1:0] sum;
        logic        [SQ_W-1:0]  sq;
        logic signed [SMP_W-1:0] min;
        logic signed [SMP_W-1:0] max;
    } stats_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- hdl/rsv_accum.sv -----
`default_nettype none
module rsv_accum (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic signed [rsv_pkg::SMP_W-1:0] sample,
    output rsv_pkg::stats_t                  stats,
    output logic                             dropped
);
    import rsv_pkg::*;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic signed [SMP_W-1:0] min_reg, min_next, max_reg, max_next;
    logic                    dropped_reg, dropped_next;
    logic [MAG_W-1:0]        mag;
    logic [2*MAG_W-1:0]      mag_sq;
    logic                    full;

    assign full   = (count_reg == {CNT_W{1'b1}});
    assign mag    = sample[SMP_W-1] ? MAG_W'(-sample) : MAG_W'(sample);
    assign mag_sq = mag * mag;

    always_comb
    begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            dropped_next = full;
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
                sum_next   = sum_reg + SUM_W'(sample);
                sq_next    = sq_reg + SQ_W'(mag_sq);
                if (count_reg == '0)
                begin
                    min_next = sample;
                    max_next = sample;
                end
                else if (sample < min_reg)
                begin
                    min_next = sample;
                end
                else if (sample > max_reg)
                begin
                    max_next = sample;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            dropped_reg <= dropped_next;
        end
    end

    // Min and max are only read once a sample has written them.
    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign stats.count = count_reg;
    assign stats.sum   = sum_reg;
    assign stats.sq    = sq_reg;
    assign stats.min   = min_reg;
    assign stats.max   = max_reg;
    assign dropped     = dropped_reg;

endmodule
`default_nettype wire

// ----- hdl/rsv_mul.sv -----
`default_nettype none
module rsv_mul (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic                         step,
    input  wire logic [rsv_pkg::MPL_W-1:0]    mplier,
    input  wire logic [rsv_pkg::MCD_W-1:0]    mcand,
    output logic      [rsv_pkg::PROD_W-1:0]   product
);
    import rsv_pkg::*;

    // Shift-and-add: one multiplier bit is retired per step, LSB first.
    logic [PROD_W-1:0] acc_reg, acc_next, mcd_reg, mcd_next;
    logic [MPL_W-1:0]  mpl_reg, mpl_next;

    always_comb
    begin
        acc_next = acc_reg;
        mcd_next = mcd_reg;
        mpl_next = mpl_reg;
        if (load)
        begin
            acc_next = '0;
            mcd_next = PROD_W'(mcand);
            mpl_next = mplier;
        end
        else if (step)
        begin
            if (mpl_reg[0])
            begin
                acc_next = acc_reg + mcd_reg;
            end
            mcd_next = {mcd_reg[PROD_W-2:0], 1'b0};
            mpl_next = {1'b0, mpl_reg[MPL_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpl_reg <= mpl_next;
    end

    assign product = acc_reg;

endmodule
`default_nettype wire

// ----- hdl/rsv_div.sv -----
`default_nettype none
module rsv_div (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic                        step,
    input  wire logic [rsv_pkg::DVD_W-1:0]   dividend,
    input  wire logic [rsv_pkg::QUO_W-1:0]   divisor,
    output logic      [rsv_pkg::QUO_W-1:0]   quotient
);
    import rsv_pkg::*;

    // Restoring division; the upper half must be below the divisor so the
    // quotient fits QUO_W bits. Quotient bits shift into the low register.
    logic [QUO_W:0]   rem_reg, rem_next;
    logic [QUO_W-1:0] lo_reg, lo_next;
    logic [QUO_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg[QUO_W-1:0], lo_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        rem_next = rem_reg;
        lo_next  = lo_reg;
        if (load)
        begin
            rem_next = {1'b0, dividend[DVD_W-1:QUO_W]};
            lo_next  = dividend[QUO_W-1:0];
        end
        else if (step)
        begin
            rem_next = fits ? (trial - {1'b0, divisor}) : trial;
            lo_next  = {lo_reg[QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
    end

    assign quotient = lo_reg;

endmodule
`default_nettype wire

// ----- hdl/rsv_sqrt.sv -----
`default_nettype none
module rsv_sqrt (
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic                        step,
    input  wire logic [rsv_pkg::QUO_W-1:0]   radicand,
    output logic      [rsv_pkg::DEV_W-1:0]   root
);
    import rsv_pkg::*;

    // Digit-by-digit square root, one result bit per step.
    logic [QUO_W-1:0] x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic [QUO_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        x_next   = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (load)
        begin
            x_next   = radicand;
            res_next = '0;
            bit_next = QUO_W'(1) << (QUO_W - 2);
        end
        else if (step)
        begin
            if (x_reg >= trial)
            begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root = res_reg[DEV_W-1:0];

endmodule
`default_nettype wire

// ----- hdl/running_stats_variance.sv -----
`default_nettype none
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// input    | in_valid / in_ready  | sample
// output   | out_valid / out_ready| sample_total, sum_all, smallest, largest,
//          |                      | variance_q8, deviation_q8, overflow
//
// The statistics update at the accepting edge. The result is then worked out in states:
// LOAD arms the multipliers, MUL runs the multiplication, DIV loads and runs the
// 48-step division, SQRT loads and runs the 24-step square root, and DONE writes it out.
// One request at a time; the next is taken once the result is loaded and the block is idle.
// Reset clears the count, sum and sum of squares; no clearing pass is needed.
// A stalled output holds its result, and a finished computation waits for it to drain.
module running_stats_variance (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [rsv_pkg::SMP_W-1:0]  sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic        [rsv_pkg::CNT_W-1:0]       sample_total,
    output logic signed [rsv_pkg::SUM_W-1:0]       sum_all,
    output logic signed [rsv_pkg::SMP_W-1:0]       smallest,
    output logic signed [rsv_pkg::SMP_W-1:0]       largest,
    output logic        [rsv_pkg::VAR_W-1:0]       variance_q8,
    output logic        [rsv_pkg::DEV_W-1:0]       deviation_q8,
    output logic                                   overflow
);
    import rsv_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;
    logic              mul_load, mul_step, div_load, div_step, sqrt_load, sqrt_step;
    logic              out_load;
    stats_t            stats;
    logic              dropped;

    logic [SUM_W-1:0]   smag;
    logic [PROD_W-1:0]  prod_ns2, prod_s1sq, prod_den;
    logic [PROD_W:0]    diff;
    logic [DVD_W-1:0]   dividend;
    logic [QUO_W-1:0]   quotient;
    logic [DEV_W-1:0]   root;
    logic               zero_reg, zero_next;

    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]        total_reg;
    logic signed [SUM_W-1:0] sum_out_reg;
    logic signed [SMP_W-1:0] min_out_reg, max_out_reg;
    logic [VAR_W-1:0]        var_reg;
    logic [DEV_W-1:0]        dev_reg;
    logic                    ovf_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    rsv_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .sample  (sample),
        .stats   (stats),
        .dropped (dropped)
    );

    // Three products run side by side: n*S2, |S1|^2 and the divisor n*(n-1).
    assign smag = stats.sum[SUM_W-1] ? SUM_W'(-stats.sum) : SUM_W'(stats.sum);

    rsv_mul u_mul_ns2 (
        .clk     (clk),
        .load    (mul_load),
        .step    (mul_step),
        .mplier  (MPL_W'(stats.count)),
        .mcand   (MCD_W'(stats.sq)),
        .product (prod_ns2)
    );

    rsv_mul u_mul_s1sq (
        .clk     (clk),
        .load    (mul_load),
        .step    (mul_step),
        .mplier  (MPL_W'(smag)),
        .mcand   (MCD_W'(smag)),
        .product (prod_s1sq)
    );

    rsv_mul u_mul_den (
        .clk     (clk),
        .load    (mul_load),
        .step    (mul_step),
        .mplier  (MPL_W'(stats.count)),
        .mcand   (MCD_W'(stats.count - CNT_W'(1))),
        .product (prod_den)
    );

    // The numerator stays below 2^78, so shifting it up by two fraction
    // widths still fits the dividend.
    assign diff     = {1'b0, prod_ns2} - {1'b0, prod_s1sq};
    assign dividend = DVD_W'(diff[PROD_W-1:0]) << (2 * FRAC_W);

    rsv_div u_div (
        .clk      (clk),
        .load     (div_load),
        .step     (div_step),
        .dividend (dividend),
        .divisor  (prod_den[QUO_W-1:0]),
        .quotient (quotient)
    );

    rsv_sqrt u_sqrt (
        .clk      (clk),
        .load     (sqrt_load),
        .step     (sqrt_step),
        .radicand (quotient),
        .root     (root)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mul_load   = 1'b0;
        mul_step   = 1'b0;
        div_load   = 1'b0;
        div_step   = 1'b0;
        sqrt_load  = 1'b0;
        sqrt_step  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mul_load   = 1'b1;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    div_load = 1'b1;
                end
                else
                begin
                    div_step = 1'b1;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS))
                begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (step_reg == '0)
                begin
                    sqrt_load = 1'b1;
                end
                else
                begin
                    sqrt_step = 1'b1;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SQRT_STEPS))
                begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Variance and deviation are zero for fewer than two samples or a
    // negative numerator.
    assign zero_next = div_load ? ((stats.count <= CNT_W'(1)) || diff[PROD_W]) : zero_reg;

    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        if (out_load)
        begin
            total_reg   <= stats.count;
            sum_out_reg <= stats.sum;
            min_out_reg <= stats.min;
            max_out_reg <= stats.max;
            var_reg     <= zero_reg ? '0 : quotient[FRAC_W +: VAR_W];
            dev_reg     <= zero_reg ? '0 : root;
            ovf_reg     <= dropped;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_total = total_reg;
    assign sum_all      = sum_out_reg;
    assign smallest     = min_out_reg;
    assign largest      = max_out_reg;
    assign variance_q8  = var_reg;
    assign deviation_q8 = dev_reg;
    assign overflow     = ovf_reg;

    // Only one request may be in flight at a time.
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while another is in flight");

    // A dropped sample is only reported when the count is full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (sample_total == {CNT_W{1'b1}}))
        else $error("overflow reported below full count");

    // Spread needs at least two samples.
    a_spread_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((variance_q8 != '0) || (deviation_q8 != '0))) |->
        (sample_total > CNT_W'(1)))
        else $error("nonzero spread with fewer than two samples");

    // The result register is only written when empty or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
module tb;
    import rsv_pkg::*;

    // One expected result of the statistics block, field for field as on the ports.
    typedef struct {
        logic        [CNT_W-1:0] total;
        logic signed [SUM_W-1:0] sum;
        logic signed [SMP_W-1:0] lo;
        logic signed [SMP_W-1:0] hi;
        logic        [VAR_W-1:0] var_q8;
        logic        [DEV_W-1:0] dev_q8;
        logic                    dropped;
    } stats_result_t;

    localparam int DIRECTED_COUNT = 20;
    localparam int RANDOM_COUNT   = 2000;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SMP_W-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic        [CNT_W-1:0] sample_total;
    logic signed [SUM_W-1:0] sum_all;
    logic signed [SMP_W-1:0] smallest;
    logic signed [SMP_W-1:0] largest;
    logic        [VAR_W-1:0] variance_q8;
    logic        [DEV_W-1:0] deviation_q8;
    logic overflow;

    running_stats_variance i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_total (sample_total),
        .sum_all      (sum_all),
        .smallest     (smallest),
        .largest      (largest),
        .variance_q8  (variance_q8),
        .deviation_q8 (deviation_q8),
        .overflow     (overflow)
    );

    // The clock runs with a period of two units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Samples waiting to be sent and statistics waiting to come back.
    logic signed [SMP_W-1:0] pending_samples[$];
    stats_result_t           expected_stats[$];

    // The testbench's own copy of the accumulated statistics.
    logic        [CNT_W-1:0] acc_count = '0;
    logic signed [SUM_W-1:0] acc_sum = '0;
    logic        [SQ_W-1:0]  acc_squares = '0;
    logic signed [SMP_W-1:0] acc_min = '0;
    logic signed [SMP_W-1:0] acc_max = '0;

    int  error_count = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  request_taken = 1'b0;
    int  send_gap = 0;
    int  recv_stall = 0;
    // While calm is set, neither side idles, so back-to-back traffic is covered too.
    bit  calm = 1'b0;

    // Integer square root, floor, by the usual bit-pair method.
    function automatic logic [63:0] isqrt_floor(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bit_pos;
        root = '0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > x)
            bit_pos = bit_pos >> 2;
        while (bit_pos != 0)
        begin
            if (x >= root + bit_pos)
            begin
                x = x - (root + bit_pos);
                root = (root >> 1) + bit_pos;
            end
            else
                root = root >> 1;
            bit_pos = bit_pos >> 2;
        end
        return root;
    endfunction

    // Quotient of a wide numerator by n(n-1), clipped to 64 bits.
    function automatic logic [63:0] clipped_quotient(input logic [127:0] num,
                                                     input logic [127:0] den);
        logic [127:0] q;
        q = num / den;
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    // Folds one sample into the statistics and works out the result it causes.
    function automatic stats_result_t fold_sample(input logic signed [SMP_W-1:0] s);
        stats_result_t r;
        logic [127:0] n;
        logic [127:0] weighted;
        logic [127:0] sum_sq;
        logic [127:0] spread;
        logic [63:0]  sum_mag;
        logic [31:0]  smag;
        r.dropped = 1'b0;
        if (acc_count == '1)
            r.dropped = 1'b1;
        else
        begin
            smag = (s < 0) ? 32'(-32'(s)) : 32'(s);
            acc_count = acc_count + 1'b1;
            acc_sum = acc_sum + s;
            acc_squares = acc_squares + SQ_W'(smag * smag);
            if (acc_count == 1)
            begin
                acc_min = s;
                acc_max = s;
            end
            else if (s < acc_min)
                acc_min = s;
            else if (s > acc_max)
                acc_max = s;
        end
        r.var_q8 = '0;
        r.dev_q8 = '0;
        if (acc_count > 1)
        begin
            n = 128'(acc_count);
            sum_mag = (acc_sum < 0) ? 64'(-acc_sum) : 64'(acc_sum);
            weighted = n * 128'(acc_squares);
            sum_sq = 128'(sum_mag) * 128'(sum_mag);
            // A negative numerator cannot occur in exact arithmetic; it leaves zeros.
            if (weighted >= sum_sq)
            begin
                spread = weighted - sum_sq;
                r.var_q8 = VAR_W'(clipped_quotient(spread << FRAC_W, n * (n - 1)));
                r.dev_q8 = DEV_W'(isqrt_floor(
                    clipped_quotient(spread << (2 * FRAC_W), n * (n - 1))));
            end
        end
        r.total = acc_count;
        r.sum = acc_sum;
        r.lo = acc_min;
        r.hi = acc_max;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one, none at all while calm.
    function automatic int pick_gap();
        if (calm)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        error_count++;
        $display("mismatch on result %0d, %s: got %0h, expected %0h",
                 results_seen, field, got, want);
    endtask

    // Driver: a new request goes out at the falling edge once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || request_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                sample <= pending_samples.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // The receiver stalls on its own schedule, and calm flips now and then.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 499) == 0)
                calm <= !calm;
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    // Accepted requests are folded into the prediction at the rising edge.
    always @(posedge clk)
    begin
        request_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
            expected_stats.push_back(fold_sample(sample));
    end

    // Monitor: each accepted result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        stats_result_t want;
        if (out_valid && out_ready)
        begin
            if (expected_stats.size() == 0)
            begin
                error_count++;
                $display("result %0d arrived with no request outstanding", results_seen);
            end
            else
            begin
                want = expected_stats.pop_front();
                if (sample_total !== want.total)
                    report_mismatch("sample_total", sample_total, want.total);
                if (sum_all !== want.sum)
                    report_mismatch("sum_all", sum_all, want.sum);
                if (smallest !== want.lo)
                    report_mismatch("smallest", smallest, want.lo);
                if (largest !== want.hi)
                    report_mismatch("largest", largest, want.hi);
                if (variance_q8 !== want.var_q8)
                    report_mismatch("variance_q8", variance_q8, want.var_q8);
                if (deviation_q8 !== want.dev_q8)
                    report_mismatch("deviation_q8", deviation_q8, want.dev_q8);
                if (overflow !== want.dropped)
                    report_mismatch("overflow", overflow, want.dropped);
            end
            results_seen++;
        end
    end

    // Watchdog: too many cycles without any handshake means the block has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int mode;
        int base;
        // Directed: extremes, constant runs with zero variance, the widest spread.
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(-16'sh8000);
        pending_samples.push_back(-16'sh8000);
        pending_samples.push_back(16'sh0000);
        pending_samples.push_back(-16'sh0001);
        pending_samples.push_back(16'sh0001);
        for (int k = 0; k < DIRECTED_COUNT - 8; k++)
            pending_samples.push_back((k % 2 == 0) ? -16'sh8000 : 16'sh7FFF);
        // Random: full range, small values, and tight clusters around a random level.
        for (int k = 0; k < RANDOM_COUNT; k++)
        begin
            if (k % 100 == 0)
                base = $urandom_range(0, 65535);
            mode = $urandom_range(0, 9);
            if (mode < 4)
                pending_samples.push_back(SMP_W'($urandom));
            else if (mode < 6)
                pending_samples.push_back(SMP_W'($urandom_range(0, 15) - 8));
            else
                pending_samples.push_back(SMP_W'(base + $urandom_range(0, 63) - 32));
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (pending_samples.size() > 0 || in_valid || expected_stats.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d samples, %0d directed, and checked %0d results with all fields",
                 DIRECTED_COUNT + RANDOM_COUNT, DIRECTED_COUNT, results_seen);
        $display("stimulus mixed full-range, small and clustered values under random stalls");
        if (error_count == 0 && expected_stats.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
